FILE: hdl/mips_subset_core_step_defines.svh
// ----------------------------------------------------------------------------
// mips_subset_core_step assertion macros
// Concurrent check wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MIPS_SUBSET_CORE_STEP_DEFINES_SVH
`define MIPS_SUBSET_CORE_STEP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define MSC_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mips_subset_core_step: check failed");

// next-cycle implication
`define MSC_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mips_subset_core_step: check failed");

`else

`define MSC_ASSERT_IMPL(name, pre, post)
`define MSC_ASSERT_NEXT(name, pre, post)

`endif

`endif

FILE: hdl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and instruction codes for the subset core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

  localparam int unsigned XLEN          = 32;
  localparam int unsigned REGS          = 32;
  localparam int unsigned RIDX_W        = 5;
  localparam int unsigned SLOT_IN_W     = 30;
  localparam int unsigned MEM_WORDS_DEF = 1024;

  // item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_WREG = 2'd2;
  localparam logic [1:0] KIND_RREG = 2'd3;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_SLT = 6'h2A;

  localparam logic [XLEN-1:0] PC_HI_MASK = 32'hF000_0000;
  localparam logic [RIDX_W-1:0] RA_IDX   = 5'd31;

  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage

`default_nettype wire

FILE: hdl/msc_regfile.sv
// ----------------------------------------------------------------------------
// msc_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msc_regfile import msc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rf_wr_t            wr,
  input  logic [RIDX_W-1:0] rd_addr_a,
  input  logic [RIDX_W-1:0] rd_addr_b,
  output logic [XLEN-1:0]   rd_data_a,
  output logic [XLEN-1:0]   rd_data_b
);

  logic [XLEN-1:0] mem [REGS];
  logic [REGS-1:0] vld_r;
  logic [XLEN-1:0] data_a_r;
  logic [XLEN-1:0] data_b_r;
  logic            vld_a_r;
  logic            vld_b_r;
  logic            wr_ok;

  // register 0 is never written, so its valid bit stays low and it reads zero
  assign wr_ok = wr.en && (wr.addr != '0);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
    data_a_r <= mem[rd_addr_a];
    data_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[wr.addr] <= 1'b1;
      end
      vld_a_r <= vld_r[rd_addr_a];
      vld_b_r <= vld_r[rd_addr_b];
    end
  end

  assign rd_data_a = vld_a_r ? data_a_r : '0;
  assign rd_data_b = vld_b_r ? data_b_r : '0;

endmodule

`default_nettype wire

FILE: hdl/msc_wmem.sv
// ----------------------------------------------------------------------------
// msc_wmem
// Single-port word memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msc_wmem import msc_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MEM_WORDS)-1:0] addr,
  input  logic [XLEN-1:0]              wr_data,
  output logic [XLEN-1:0]              rd_data
);

  logic [XLEN-1:0] mem [MEM_WORDS];
  logic [XLEN-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/msc_slot.sv
// ----------------------------------------------------------------------------
// msc_slot
// Two-stage word index reduction: x mod MEM_WORDS by reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msc_slot import msc_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic [SLOT_IN_W-1:0]         x,
  output logic [$clog2(MEM_WORDS)-1:0] slot
);

  localparam int unsigned AW     = $clog2(MEM_WORDS);
  localparam int unsigned SH     = SLOT_IN_W + AW;
  localparam int unsigned PW     = SLOT_IN_W + 32;
  localparam logic [63:0] RECIP_W =
    ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
  localparam logic [31:0] RECIP  = RECIP_W[31:0];
  localparam logic [SLOT_IN_W-1:0] MW = SLOT_IN_W'(MEM_WORDS);

  logic [PW-1:0]        prod_r;
  logic [SLOT_IN_W-1:0] x1_r;
  logic [SLOT_IN_W-1:0] x2_r;
  logic [SLOT_IN_W-1:0] qm_r;
  logic [SLOT_IN_W-1:0] quot;
  logic [SLOT_IN_W-1:0] rem;

  // exact floor(x / MEM_WORDS) for every 30-bit x
  assign quot = SLOT_IN_W'(prod_r >> SH);

  always_ff @(posedge clk) begin
    prod_r <= PW'(x) * PW'(RECIP);
    x1_r   <= x;
    qm_r   <= SLOT_IN_W'(quot * MW);
    x2_r   <= x1_r;
  end

  assign rem  = x2_r - qm_r;
  assign slot = rem[AW-1:0];

endmodule

`default_nettype wire

FILE: hdl/mips_subset_core_step.sv
// ----------------------------------------------------------------------------
// mips_subset_core_step
// Small MIPS-style core stepped one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mips_subset_core_step_defines.svh"

// Each input word loads a memory word, executes the instruction at the PC,
// writes a register or reads a register, and yields exactly one result word
// (status, PC after the word, read data). One word is handled at a time; the
// output register lets the next word in while a result is still waiting.
// A register write goes straight to its result, a register read first
// reads the register file, and a load or fetch first folds the word index;
// lw and sw then fold their data address too. The single port of the word
// memory (fetch and data access take turns on it) and the two-stage unit
// that folds a word index into the memory depth set how long a word takes.
// Memory is swept to zero after reset, one word a cycle, before input is taken.

module mips_subset_core_step import msc_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_reg_index,
  input  logic [9:0]  in_word_address,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [31:0] out_pc_value,
  output logic [31:0] out_read_data
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;   // memory clearing sweep
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;   // index reduction, first stage
  localparam logic [3:0] S_W2   = 4'd3;   // index ready: load write or fetch
  localparam logic [3:0] S_DEC  = 4'd4;   // instruction out of memory
  localparam logic [3:0] S_EXE  = 4'd5;   // operands out of register file
  localparam logic [3:0] S_D1   = 4'd6;   // data address reduction
  localparam logic [3:0] S_D2   = 4'd7;   // lw read / sw write
  localparam logic [3:0] S_LWD  = 4'd8;   // lw write-back
  localparam logic [3:0] S_RDR  = 4'd9;   // register read data
  localparam logic [3:0] S_DONE = 4'd10;  // hand result to output register

  logic [3:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [XLEN-1:0]   pc_r, pc_nxt;
  logic [1:0]        kind_r;
  logic [XLEN-1:0]   data_r;
  logic [XLEN-1:0]   ins_r;
  logic [XLEN-1:0]   b_r;
  logic              status_pend_r, status_pend_nxt;
  logic [XLEN-1:0]   rdata_pend_r;

  logic              out_valid_r;
  logic              out_status_r;
  logic [XLEN-1:0]   out_pc_value_r;
  logic [XLEN-1:0]   out_read_data_r;

  logic              accept;
  logic              out_load;

  // memory-side nets
  logic [SLOT_IN_W-1:0] slot_x;
  logic [AW-1:0]        slot;
  logic                 wm_wr_en;
  logic [AW-1:0]        wm_addr;
  logic [XLEN-1:0]      wm_wr_data;
  logic [XLEN-1:0]      wm_rd_data;

  rf_wr_t               rf_wr;
  logic [RIDX_W-1:0]    rf_addr_a;
  logic [RIDX_W-1:0]    rf_addr_b;
  logic [XLEN-1:0]      rf_a;
  logic [XLEN-1:0]      rf_b;

  // execute stage
  logic [5:0]        op;
  logic [5:0]        fn;
  logic [XLEN-1:0]   simm;
  logic [XLEN-1:0]   zimm;
  logic [XLEN-1:0]   pc_plus4;
  logic [XLEN-1:0]   mem_sum;
  logic              exe_wr_en;
  logic [RIDX_W-1:0] exe_wr_addr;
  logic [XLEN-1:0]   exe_wr_val;
  logic [XLEN-1:0]   exe_pc;
  logic              exe_unknown;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Instruction decode and ALU (operands valid in S_EXE)
  // --------------------------------------------------------------------------
  assign op       = ins_r[31:26];
  assign fn       = ins_r[5:0];
  assign simm     = {{16{ins_r[15]}}, ins_r[15:0]};
  assign zimm     = {16'h0000, ins_r[15:0]};
  assign pc_plus4 = pc_r + 32'd4;
  assign mem_sum  = rf_a + simm;

  always_comb begin
    exe_wr_en   = 1'b0;
    exe_wr_addr = ins_r[20:16];
    exe_wr_val  = '0;
    exe_pc      = pc_plus4;
    exe_unknown = 1'b0;
    unique case (op)
      OP_RTYPE: begin
        exe_wr_addr = ins_r[15:11];
        exe_wr_en   = 1'b1;
        unique case (fn)
          FN_ADD:  exe_wr_val = rf_a + rf_b;
          FN_SUB:  exe_wr_val = rf_a - rf_b;
          FN_AND:  exe_wr_val = rf_a & rf_b;
          FN_OR:   exe_wr_val = rf_a | rf_b;
          FN_SLT:  exe_wr_val = {31'd0, ($signed(rf_a) < $signed(rf_b))};
          default: begin
            exe_wr_en   = 1'b0;
            exe_unknown = 1'b1;
          end
        endcase
      end
      OP_ADDI: begin
        exe_wr_en  = 1'b1;
        exe_wr_val = mem_sum;
      end
      OP_ANDI: begin
        exe_wr_en  = 1'b1;
        exe_wr_val = rf_a & zimm;
      end
      OP_ORI: begin
        exe_wr_en  = 1'b1;
        exe_wr_val = rf_a | zimm;
      end
      OP_LW, OP_SW: begin
        // handled by the data access states
      end
      OP_BEQ: begin
        if (rf_a == rf_b) begin
          exe_pc = pc_plus4 + {simm[29:0], 2'b00};
        end
      end
      OP_J: begin
        exe_pc = (pc_plus4 & PC_HI_MASK) | {4'h0, ins_r[25:0], 2'b00};
      end
      OP_JAL: begin
        exe_wr_en   = 1'b1;
        exe_wr_addr = RA_IDX;
        exe_wr_val  = pc_plus4;
        exe_pc      = (pc_plus4 & PC_HI_MASK) | {4'h0, ins_r[25:0], 2'b00};
      end
      default: begin
        exe_unknown = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory and register file port steering
  // --------------------------------------------------------------------------
  always_comb begin
    if (state_r == S_EXE) begin
      slot_x = mem_sum[31:2];
    end else if (in_kind == KIND_EXEC) begin
      slot_x = pc_r[31:2];
    end else begin
      slot_x = SLOT_IN_W'(in_word_address);
    end
  end

  always_comb begin
    wm_wr_en   = 1'b0;
    wm_addr    = slot;
    wm_wr_data = data_r;
    if (state_r == S_CLR) begin
      wm_wr_en   = 1'b1;
      wm_addr    = clr_cnt_r;
      wm_wr_data = '0;
    end else if (state_r == S_W2 && kind_r == KIND_LOAD) begin
      wm_wr_en = 1'b1;
    end else if (state_r == S_D2 && op == OP_SW) begin
      wm_wr_en   = 1'b1;
      wm_wr_data = b_r;
    end
  end

  // the instruction's register fields come straight off the memory in S_DEC
  assign rf_addr_a = (state_r == S_DEC) ? wm_rd_data[25:21] : in_reg_index;
  assign rf_addr_b = wm_rd_data[20:16];

  always_comb begin
    rf_wr.en   = 1'b0;
    rf_wr.addr = in_reg_index;
    rf_wr.data = in_write_data;
    if (accept && in_kind == KIND_WREG) begin
      rf_wr.en = 1'b1;
    end else if (state_r == S_EXE) begin
      rf_wr.en   = exe_wr_en;
      rf_wr.addr = exe_wr_addr;
      rf_wr.data = exe_wr_val;
    end else if (state_r == S_LWD) begin
      rf_wr.en   = 1'b1;
      rf_wr.addr = ins_r[20:16];
      rf_wr.data = wm_rd_data;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    pc_nxt          = pc_r;
    status_pend_nxt = status_pend_r;
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          status_pend_nxt = 1'b0;
          unique case (in_kind)
            KIND_LOAD, KIND_EXEC: state_nxt = S_W1;
            KIND_WREG:            state_nxt = S_DONE;
            KIND_RREG:            state_nxt = S_RDR;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_W1:  state_nxt = S_W2;
      S_W2:  state_nxt = (kind_r == KIND_LOAD) ? S_DONE : S_DEC;
      S_DEC: state_nxt = S_EXE;
      S_EXE: begin
        pc_nxt          = exe_pc;
        status_pend_nxt = exe_unknown;
        state_nxt       = (op == OP_LW || op == OP_SW) ? S_D1 : S_DONE;
      end
      S_D1:  state_nxt = S_D2;
      S_D2:  state_nxt = (op == OP_LW) ? S_LWD : S_DONE;
      S_LWD: state_nxt = S_DONE;
      S_RDR: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_cnt_r     <= '0;
      pc_r          <= '0;
      status_pend_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      pc_r          <= pc_nxt;
      status_pend_r <= status_pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= in_kind;
      data_r       <= in_write_data;
      rdata_pend_r <= '0;
    end
    if (state_r == S_RDR) begin
      rdata_pend_r <= rf_a;
    end
    if (state_r == S_DEC) begin
      ins_r <= wm_rd_data;
    end
    if (state_r == S_EXE) begin
      b_r <= rf_b;
    end
    if (out_load) begin
      out_status_r    <= status_pend_r;
      out_pc_value_r  <= pc_r;
      out_read_data_r <= rdata_pend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pc_value  = out_pc_value_r;
  assign out_read_data = out_read_data_r;

  // --------------------------------------------------------------------------
  // Storage and address unit
  // --------------------------------------------------------------------------
  msc_slot #(
    .MEM_WORDS (MEM_WORDS)
  ) u_slot (
    .clk  (clk),
    .x    (slot_x),
    .slot (slot)
  );

  msc_wmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_wmem (
    .clk     (clk),
    .wr_en   (wm_wr_en),
    .addr    (wm_addr),
    .wr_data (wm_wr_data),
    .rd_data (wm_rd_data)
  );

  msc_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (rf_wr),
    .rd_addr_a (rf_addr_a),
    .rd_addr_b (rf_addr_b),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `MSC_ASSERT_NEXT(a_one_word_in_flight, accept, in_stall)
  `MSC_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)
  `MSC_ASSERT_IMPL(a_no_result_in_clear, state_r == S_CLR, !out_valid_r)
  `MSC_ASSERT_IMPL(a_status_exec_only, state_r == S_DONE && status_pend_r, kind_r == KIND_EXEC)

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: subset core step testbench
// Drives load, execute, register write and register read words into the
// core and checks every result word (status, PC, read data) against a
// shadow copy of the register file, word memory and PC kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import msc_pkg::*;

  localparam int unsigned MEM_DEPTH = MEM_WORDS_DEF;

  // funct code that no R-type operation uses
  localparam logic [5:0] FN_BAD = 6'h3F;

  typedef struct packed {
    logic        status;
    logic [31:0] pc;
    logic [31:0] rdata;
  } core_result_t;

  // --------------------------------------------------------------------------
  // Clock, DUT ports
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [4:0]  in_reg_index;
  logic [9:0]  in_word_address;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [31:0] out_pc_value;
  logic [31:0] out_read_data;

  always #2 clk = ~clk;

  mips_subset_core_step #(
    .MEM_WORDS(MEM_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_reg_index   (in_reg_index),
    .in_word_address(in_word_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_pc_value   (out_pc_value),
    .out_read_data  (out_read_data)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the core and the queue of results still owed by the DUT
  // --------------------------------------------------------------------------
  logic [31:0]  shadow_regs [REGS];
  logic [31:0]  shadow_mem  [MEM_DEPTH];
  logic [31:0]  shadow_pc;
  core_result_t pending_results [$];

  int err_cnt = 0;

  // traffic shaping knobs, flipped by the test tasks
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int hold_left  = 0;   // long receiver hold-off, counted down by rx process

  // byte address -> word slot; low two bits dropped, wraps at memory depth
  function automatic int unsigned mem_slot(logic [31:0] byte_addr);
    return (byte_addr >> 2) % MEM_DEPTH;
  endfunction

  // r0 is hardwired to zero on both read and write
  function automatic logic [31:0] shadow_rd(logic [4:0] n);
    return (n == '0) ? 32'h0 : shadow_regs[n];
  endfunction

  function automatic void shadow_wr(logic [4:0] n, logic [31:0] v);
    if (n != '0) shadow_regs[n] = v;
  endfunction

  // Advance the shadow core by one accepted word and return what the DUT
  // must answer.
  function automatic core_result_t predict_core_step(logic [1:0] kind, logic [4:0] ridx,
                                                     logic [9:0] waddr, logic [31:0] wdata);
    core_result_t res;
    logic [31:0]  ins;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  simm;
    logic [5:0]   op;
    logic [5:0]   fn;
    logic [4:0]   rs;
    logic [4:0]   rt;
    logic [4:0]   rd;
    logic [15:0]  imm;
    res = '0;
    case (kind)
      KIND_LOAD: shadow_mem[waddr % MEM_DEPTH] = wdata;
      KIND_WREG: shadow_wr(ridx, wdata);
      KIND_RREG: res.rdata = shadow_rd(ridx);
      default: begin
        ins  = shadow_mem[mem_slot(shadow_pc)];
        op   = ins[31:26];
        rs   = ins[25:21];
        rt   = ins[20:16];
        rd   = ins[15:11];
        fn   = ins[5:0];
        imm  = ins[15:0];
        simm = {{16{imm[15]}}, imm};
        a    = shadow_rd(rs);
        b    = shadow_rd(rt);
        // all targets are relative to the PC already bumped by 4
        shadow_pc = shadow_pc + 32'd4;
        case (op)
          OP_RTYPE: begin
            // shamt is don't-care for every supported funct
            case (fn)
              FN_ADD:  shadow_wr(rd, a + b);
              FN_SUB:  shadow_wr(rd, a - b);
              FN_AND:  shadow_wr(rd, a & b);
              FN_OR:   shadow_wr(rd, a | b);
              FN_SLT:  shadow_wr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
              default: res.status = 1'b1;
            endcase
          end
          OP_ADDI: shadow_wr(rt, a + simm);
          OP_ANDI: shadow_wr(rt, a & {16'h0, imm});
          OP_ORI:  shadow_wr(rt, a | {16'h0, imm});
          OP_LW:   shadow_wr(rt, shadow_mem[mem_slot(a + simm)]);
          OP_SW:   shadow_mem[mem_slot(a + simm)] = b;
          OP_BEQ:  if (a == b) shadow_pc = shadow_pc + {simm[29:0], 2'b00};
          OP_J:    shadow_pc = (shadow_pc & PC_HI_MASK) | {4'h0, ins[25:0], 2'b00};
          OP_JAL: begin
            shadow_wr(RA_IDX, shadow_pc);
            shadow_pc = (shadow_pc & PC_HI_MASK) | {4'h0, ins[25:0], 2'b00};
          end
          default: res.status = 1'b1;
        endcase
      end
    endcase
    res.pc = shadow_pc;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Instruction encoders and biased random pickers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // mostly a few low registers so results feed later instructions
  function automatic logic [4:0] pick_reg();
    logic [31:0] r;
    r = $urandom;
    return ($urandom_range(0, 3) == 0) ? r[4:0] : {2'b00, r[2:0]};
  endfunction

  function automatic logic [15:0] pick_imm();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return {12'h0, r[3:0]};
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return {26'h0, r[5:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [31:0] pick_instr();
    logic [31:0] r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [15:0] off;
    r = $urandom;
    case ($urandom_range(0, 15))
      0:  return enc_r(pick_reg(), pick_reg(), pick_reg(), r[4:0], FN_ADD);
      1:  return enc_r(pick_reg(), pick_reg(), pick_reg(), r[4:0], FN_SUB);
      2:  return enc_r(pick_reg(), pick_reg(), pick_reg(), r[4:0], FN_AND);
      3:  return enc_r(pick_reg(), pick_reg(), pick_reg(), r[4:0], FN_OR);
      4:  return enc_r(pick_reg(), pick_reg(), pick_reg(), r[4:0], FN_SLT);
      5:  return enc_i(OP_ADDI, pick_reg(), pick_reg(), pick_imm());
      6:  return enc_i(OP_ANDI, pick_reg(), pick_reg(), pick_imm());
      7:  return enc_i(OP_ORI,  pick_reg(), pick_reg(), pick_imm());
      8:  return enc_i(OP_LW,   pick_reg(), pick_reg(), pick_imm());
      9:  return enc_i(OP_SW,   pick_reg(), pick_reg(), pick_imm());
      10: begin
        // same source twice half the time so the branch is often taken
        rs  = pick_reg();
        off = r[16] ? pick_imm() : {{12{r[3]}}, r[3:0]};
        return enc_i(OP_BEQ, rs, r[17] ? rs : pick_reg(), off);
      end
      11: return {OP_J,   r[25:0]};
      12: return {OP_JAL, r[25:0]};
      13: begin
        do fn = 6'($urandom); while (fn inside {FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT});
        return enc_r(pick_reg(), pick_reg(), pick_reg(), r[4:0], fn);
      end
      14: begin
        do op = 6'($urandom);
        while (op inside {OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_ADDI, OP_ANDI, OP_ORI,
                          OP_LW, OP_SW});
        return {op, r[25:0]};
      end
      default: return r;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Inputs move on the falling edge; a word is taken at the
  // rising edge where valid is high and in_stall is low. Valid is left high
  // after a handoff so back-to-back words never toggle it within one step.
  // --------------------------------------------------------------------------
  task automatic send_word(logic [1:0] kind, logic [4:0] ridx, logic [9:0] waddr,
                           logic [31:0] wdata);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_kind         = kind;
    in_reg_index    = ridx;
    in_word_address = waddr;
    in_write_data   = wdata;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_core_step(kind, ridx, waddr, wdata));
  endtask

  // unused fields always carry random bits
  task automatic load_word(logic [9:0] waddr, logic [31:0] wdata);
    logic [31:0] r;
    r = $urandom;
    send_word(KIND_LOAD, r[4:0], waddr, wdata);
  endtask

  task automatic exec_word();
    logic [31:0] r;
    r = $urandom;
    send_word(KIND_EXEC, r[4:0], r[14:5], $urandom);
  endtask

  task automatic write_reg(logic [4:0] idx, logic [31:0] val);
    logic [31:0] r;
    r = $urandom;
    send_word(KIND_WREG, idx, r[9:0], val);
  endtask

  task automatic read_reg(logic [4:0] idx);
    logic [31:0] r;
    r = $urandom;
    send_word(KIND_RREG, idx, r[9:0], $urandom);
  endtask

  // any kind, any field values
  task automatic noise_word();
    logic [31:0] r;
    r = $urandom;
    send_word(r[1:0], r[6:2], r[16:7], $urandom);
  endtask

  // drop valid and hold off until the DUT has answered everything
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Most often "load the word at the PC, then run it", so every instruction
  // class gets exercised with live register contents.
  task automatic random_step();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 48) begin
      load_word(10'(mem_slot(shadow_pc)), pick_instr());
      exec_word();
    end else if (sel < 60) begin
      exec_word();   // whatever is in memory at the PC, often data or zero
    end else if (sel < 75) begin
      write_reg(pick_reg(), pick_word());
    end else if (sel < 90) begin
      read_reg(pick_reg());
    end else begin
      noise_word();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, a long hold-off on request, or none
  // --------------------------------------------------------------------------
  initial begin : rx_side
    int seg_left;
    bit seg_stall;
    seg_left  = 0;
    seg_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (!rx_idle_on) begin
        out_stall = 1'b0;
        seg_left  = 0;
      end else begin
        if (seg_left == 0) begin
          seg_stall = ($urandom_range(0, 2) == 0);
          seg_left  = seg_stall ? $urandom_range(1, 14) : $urandom_range(1, 24);
        end
        out_stall = seg_stall;
        seg_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    core_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", out_pc_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", {31'h0, out_status}, {31'h0, want.status});
        if (out_pc_value !== want.pc)
          report_mismatch("pc_value", out_pc_value, want.pc);
        if (out_read_data !== want.rdata)
          report_mismatch("read_data", out_read_data, want.rdata);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // r0 drops writes and reads zero; register extremes set up for later
  task automatic test_register_file_basics();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_reg(5'd1, 32'h7FFF_FFFF);
    write_reg(5'd2, 32'h8000_0000);
    write_reg(5'd0, 32'hFFFF_FFFF);
    read_reg(5'd0);
  endtask

  // One of each operation but j, laid out as a straight program from word 0.
  task automatic test_each_instruction();
    load_word(10'd0,  enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD));    // max + min
    load_word(10'd1,  enc_r(5'd2, 5'd1, 5'd4, 5'd0, FN_SUB));    // wraps to 1
    load_word(10'd2,  enc_r(5'd2, 5'd1, 5'd5, 5'd0, FN_SLT));    // signed: 1
    load_word(10'd3,  enc_r(5'd1, 5'd3, 5'd6, 5'd0, FN_AND));
    load_word(10'd4,  enc_r(5'd1, 5'd2, 5'd7, 5'd5, FN_OR));     // shamt ignored
    load_word(10'd5,  enc_i(OP_ADDI, 5'd1, 5'd8, 16'h0001));     // overflow wraps
    load_word(10'd6,  enc_i(OP_ANDI, 5'd3, 5'd9, 16'hFFFF));
    load_word(10'd7,  enc_i(OP_ORI,  5'd0, 5'd10, 16'h8000));    // zero-extended
    // byte address -4 lands on the last word; r1 there decodes as a bad opcode
    load_word(10'd8,  enc_i(OP_SW,   5'd0, 5'd1, 16'hFFFC));
    load_word(10'd9,  enc_i(OP_LW,   5'd0, 5'd11, 16'hFFFD));    // low bits ignored
    load_word(10'd10, enc_i(OP_BEQ,  5'd3, 5'd7, 16'h0001));     // taken, skips 11
    load_word(10'd12, enc_r(5'd1, 5'd2, 5'd12, 5'd0, FN_BAD));   // bad funct
    load_word(10'd13, {OP_JAL, 26'd1023});                       // to last word
    repeat (11) exec_word();   // words 0..10
    exec_word();               // word 12
    exec_word();               // word 13, jal
    exec_word();               // last word: unknown opcode, PC walks off the end
    exec_word();               // fetch wraps back to word 0
    read_reg(RA_IDX);
    read_reg(5'd11);
    read_reg(5'd5);
    read_reg(5'd10);
    wait_drained();
  endtask

  task automatic test_random_programs(int steps);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (steps) random_step();
    wait_drained();
  endtask

  // Receiver shuts off for a long stretch while words keep coming, so the
  // core fills and pushes back on its input; then the sender waits it out.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_left  = 80;
    repeat (30) random_step();
    wait_drained();
  endtask

  task automatic test_unfiltered_items(int count);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (count) noise_word();
    wait_drained();
  endtask

  // no idling anywhere for the tail of the run
  task automatic test_full_rate(int steps);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (steps) random_step();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held low at the start; the core then clears its
  // memory on its own and simply stalls the first word until it is done.
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_LOAD;
    in_reg_index    = '0;
    in_word_address = '0;
    in_write_data   = '0;
    for (int i = 0; i < REGS; i++) shadow_regs[i] = '0;
    for (int i = 0; i < MEM_DEPTH; i++) shadow_mem[i] = '0;
    shadow_pc = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_register_file_basics();
    test_each_instruction();
    test_random_programs(450);
    test_backpressure();
    test_unfiltered_items(100);
    test_full_rate(60);

    wait_drained();
    // a few cycles of quiet to catch any stray result word
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/msc_pkg.sv
hdl/msc_regfile.sv
hdl/msc_wmem.sv
hdl/msc_slot.sv
hdl/mips_subset_core_step.sv
dv/tb_top.sv
